/* rtl/gha_pkg.sv */
// Shared types and constants for the generational handle allocator.
// Holds the request and result beat structs, the slot entry layout and the codes.
// No dependencies.
package gha_pkg;

	// Table geometry; the field widths of the beats are fixed by these.
	localparam int SLOT_COUNT = 1024;
	localparam int GENERATION_BITS = 16;
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_CHECK = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// One request beat.
	typedef struct packed {
		logic [1:0] mode;
		logic [IDX_W-1:0] slot_index;
		logic [GENERATION_BITS-1:0] generation;
		logic failed_mark;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] status;
		logic [IDX_W-1:0] handle_index;
		logic [GENERATION_BITS-1:0] handle_generation;
		logic is_valid;
	} rsp_t;

	// One entry of the slot table memory.
	typedef struct packed {
		logic occupied;
		logic [GENERATION_BITS-1:0] gen;
	} slot_t;

endpackage

/* rtl/generational_handle_allocator_unit.sv */
// Generational handle allocator: slot table and free stack kept in two memories.
// done rises from the registered finish of ST_LOOKUP, or of ST_POP for an allocate that pops
// the free stack (stack read, then slot table read). A new request is accepted only while
// idle, and busy stays high through the read-modify-write.
// Reset clears the counters and control; memory contents are not cleared.
// Results are shown for one cycle on done and cannot be stalled. Depends on gha_pkg.
module generational_handle_allocator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  gha_pkg::req_t req,
	output logic          done,
	output gha_pkg::rsp_t result
);

	// One-hot sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_POP    = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Memories: slot table and free stack.
	gha_pkg::slot_t slot_mem [gha_pkg::SLOT_COUNT];
	logic [gha_pkg::IDX_W-1:0] stack_mem [gha_pkg::SLOT_COUNT];

	gha_pkg::req_t req_q;
	logic [gha_pkg::CNT_W-1:0] fs_cnt_q, fs_cnt_d;
	logic [gha_pkg::CNT_W-1:0] used_cnt_q, used_cnt_d;
	gha_pkg::slot_t slot_rd_q;
	logic [gha_pkg::IDX_W-1:0] stk_rd_q;
	logic done_q;
	gha_pkg::rsp_t result_q;

	logic accept;
	logic [gha_pkg::IDX_W-1:0] slot_raddr;
	logic [gha_pkg::IDX_W-1:0] stk_raddr;
	logic slot_we;
	logic [gha_pkg::IDX_W-1:0] slot_waddr;
	gha_pkg::slot_t slot_wdata;
	logic stk_we;
	logic [gha_pkg::IDX_W-1:0] stk_waddr;
	logic [gha_pkg::IDX_W-1:0] stk_wdata;
	logic handle_ok;
	logic fin;
	gha_pkg::rsp_t rsp_d;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign result = result_q;

	// Read addresses: the stack top is read every cycle; the slot table is read at the
	// request index on accept, and at the popped slot while looking up.
	assign stk_raddr = gha_pkg::IDX_W'(fs_cnt_q - gha_pkg::CNT_W'(1));
	assign slot_raddr = (state_q == ST_LOOKUP) ? stk_rd_q : req.slot_index;

	// A handle is valid when it is in range, occupied, of the same generation and not failed.
	assign handle_ok = (gha_pkg::CNT_W'(req_q.slot_index) < used_cnt_q)
		&& slot_rd_q.occupied
		&& (slot_rd_q.gen == req_q.generation)
		&& !req_q.failed_mark;

	// Sequencer and read-modify-write decisions.
	always_comb begin
		state_d = state_q;
		fs_cnt_d = fs_cnt_q;
		used_cnt_d = used_cnt_q;
		slot_we = 1'b0;
		slot_waddr = req_q.slot_index;
		slot_wdata = '0;
		stk_we = 1'b0;
		stk_waddr = gha_pkg::IDX_W'(fs_cnt_q);
		stk_wdata = req_q.slot_index;
		fin = 1'b0;
		rsp_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				fin = 1'b1;
				state_d = ST_IDLE;
				case (req_q.mode)
					gha_pkg::MODE_ALLOC: begin
						if (fs_cnt_q != '0) begin
							// Reuse a freed slot; its generation is read next cycle.
							fin = 1'b0;
							state_d = ST_POP;
						end else if (used_cnt_q < gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT)) begin
							// Grow the table by one fresh slot of generation zero.
							slot_we = 1'b1;
							slot_waddr = gha_pkg::IDX_W'(used_cnt_q);
							slot_wdata.occupied = 1'b1;
							slot_wdata.gen = '0;
							used_cnt_d = used_cnt_q + gha_pkg::CNT_W'(1);
							rsp_d.handle_index = gha_pkg::IDX_W'(used_cnt_q);
						end else begin
							rsp_d.status = gha_pkg::STATUS_FULL;
						end
					end
					gha_pkg::MODE_RELEASE: begin
						if (handle_ok) begin
							// Free the slot, bump its generation and push it on the stack.
							slot_we = 1'b1;
							slot_wdata.occupied = 1'b0;
							slot_wdata.gen = slot_rd_q.gen + gha_pkg::GENERATION_BITS'(1);
							if (fs_cnt_q < gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT)) begin
								stk_we = 1'b1;
								fs_cnt_d = fs_cnt_q + gha_pkg::CNT_W'(1);
							end
							rsp_d.is_valid = 1'b1;
						end else begin
							rsp_d.status = gha_pkg::STATUS_INVALID;
						end
					end
					gha_pkg::MODE_CHECK: begin
						rsp_d.is_valid = handle_ok;
					end
					default: begin
						rsp_d.status = gha_pkg::STATUS_INVALID;
					end
				endcase
			end
			ST_POP: begin
				// Mark the popped slot occupied and hand it out with its stored generation.
				fin = 1'b1;
				state_d = ST_IDLE;
				fs_cnt_d = fs_cnt_q - gha_pkg::CNT_W'(1);
				slot_we = 1'b1;
				slot_waddr = stk_rd_q;
				slot_wdata.occupied = 1'b1;
				slot_wdata.gen = slot_rd_q.gen;
				rsp_d.handle_index = stk_rd_q;
				rsp_d.handle_generation = slot_rd_q.gen;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fs_cnt_q <= '0;
			used_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fs_cnt_q <= fs_cnt_d;
			used_cnt_q <= used_cnt_d;
			done_q <= fin;
		end
	end

	// Request capture and result beat register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (fin) begin
			result_q <= rsp_d;
		end
	end

	// Slot table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// Free stack memory with a registered read port.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stack_mem[stk_raddr];
	end

endmodule
